// File: design/tms_pkg.sv
// shared codes, command and status types for the turing machine stepper
`default_nettype none
package tms_pkg;
	localparam logic [2:0] ACT_CLEAR    = 3'd0;
	localparam logic [2:0] ACT_ADD_RULE = 3'd1;
	localparam logic [2:0] ACT_APPEND   = 3'd2;
	localparam logic [2:0] ACT_START    = 3'd3;
	localparam logic [2:0] ACT_STEP     = 3'd4;
	localparam logic [2:0] ACT_READ     = 3'd5;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_ACCEPT = 2'd1;
	localparam logic [1:0] MODE_REJECT = 2'd2;
	localparam logic [1:0] MODE_ERROR  = 2'd3;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_TABLE_FULL = 2'd1;
	localparam logic [1:0] ST_TAPE_FULL  = 2'd2;
	localparam logic [1:0] ST_NO_RULE    = 2'd3;

	localparam logic [1:0] MOVE_LEFT  = 2'd1;
	localparam logic [1:0] MOVE_RIGHT = 2'd2;

	localparam logic [1:0] CFG_START  = 2'd0;
	localparam logic [1:0] CFG_ACCEPT = 2'd1;
	localparam logic [1:0] CFG_REJECT = 2'd2;

	localparam logic [7:0] SYM_ANY   = 8'h2A;
	localparam logic [7:0] SYM_BLANK = 8'h5F;

	typedef struct packed {
		logic latch;
		logic tape_rd;
		logic match;
		logic sel;
		logic exec;
		logic grow;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic grow_req;
	} stat_t;
endpackage
`default_nettype wire

// File: design/turing_machine_stepper.sv
// top level of the single-tape turing machine stepper
//
//  channel  direction  handshake            payload
//  in       request in in_valid / in_stall  action, rule_*, tape_symbol, cell_index
//  out      result out out_valid / out_stall status, run_mode_out, ... tape_used
//  cfg      write      cfg_we               cfg_index, cfg_data
//
// one request at a time; clear, add rule, append and start only execute, read
// cell reads the tape ram then executes, step does tape ram read, rule match,
// rule ram read, execute, plus a tape write when the tape grows at an edge
// reset clears counts, head, state and mode; ram contents stay undefined
// the next request is taken while a result still waits under out_stall
`default_nettype none
module turing_machine_stepper #(
	parameter int RULE_SLOTS = 64,
	parameter int TAPE_CELLS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [5:0]  rule_state,
	input  wire logic [7:0]  rule_read,
	input  wire logic [7:0]  rule_write,
	input  wire logic [1:0]  rule_move,
	input  wire logic [5:0]  rule_next,
	input  wire logic [7:0]  tape_symbol,
	input  wire logic [9:0]  cell_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [1:0]       run_mode_out,
	output logic             still_running,
	output logic [5:0]       state_out,
	output logic [9:0]       head_out,
	output logic [7:0]       symbol_read,
	output logic [7:0]       cell_value,
	output logic [10:0]      tape_used,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [5:0]  cfg_data
);
	import tms_pkg::*;

	// command and status between sequencer and datapath
	cmd_t  cmd;
	stat_t stat;

	// sequencer: walks each request through its phases
	tms_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .stat(stat)
	);

	// datapath: rule keys matched in parallel, rule and tape rams
	tms_dp #(.RULE_SLOTS(RULE_SLOTS), .TAPE_CELLS(TAPE_CELLS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.action(action), .rule_state(rule_state), .rule_read(rule_read),
		.rule_write(rule_write), .rule_move(rule_move), .rule_next(rule_next),
		.tape_symbol(tape_symbol), .cell_index(cell_index),
		.status(status), .run_mode_out(run_mode_out),
		.still_running(still_running), .state_out(state_out),
		.head_out(head_out), .symbol_read(symbol_read),
		.cell_value(cell_value), .tape_used(tape_used)
	);
endmodule
`default_nettype wire

// File: design/tms_ram.sv
// generic single write, single read ram with registered read
`default_nettype none
module tms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// File: design/tms_ctrl.sv
// sequencer for the turing machine stepper
`default_nettype none
module tms_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [2:0]    action,
	output logic               out_valid,
	input  wire logic          out_stall,
	output tms_pkg::cmd_t      cmd,
	input  wire tms_pkg::stat_t stat
);
	import tms_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_MATCH, S_SEL, S_EXEC, S_GROW, S_DONE
	} state_t;

	state_t state_q;
	logic   out_free;
	// remembers whether the request in flight is a cell read
	logic   cmd_is_read_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		cmd          = '0;
		cmd.latch    = (state_q == S_IDLE) && in_valid;
		cmd.tape_rd  = (state_q == S_RD);
		cmd.match    = (state_q == S_MATCH);
		cmd.sel      = (state_q == S_SEL);
		cmd.exec     = (state_q == S_EXEC);
		cmd.grow     = (state_q == S_GROW);
		cmd.load_out = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid     <= 1'b0;
			cmd_is_read_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_is_read_q <= (action == ACT_READ);
						if (action == ACT_STEP || action == ACT_READ) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_RD:    state_q <= (cmd_is_read_q) ? S_EXEC : S_MATCH;
				S_MATCH: state_q <= S_SEL;
				S_SEL:   state_q <= S_EXEC;
				S_EXEC:  state_q <= stat.grow_req ? S_GROW : S_DONE;
				S_GROW:  state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: design/tms_dp.sv
// datapath: rule store, circular tape, head, state and result registers
`default_nettype none
module tms_dp #(
	parameter int RULE_SLOTS = 64,
	parameter int TAPE_CELLS = 1024
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tms_pkg::cmd_t cmd,
	output tms_pkg::stat_t     stat,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [5:0]    cfg_data,
	input  wire logic [2:0]    action,
	input  wire logic [5:0]    rule_state,
	input  wire logic [7:0]    rule_read,
	input  wire logic [7:0]    rule_write,
	input  wire logic [1:0]    rule_move,
	input  wire logic [5:0]    rule_next,
	input  wire logic [7:0]    tape_symbol,
	input  wire logic [9:0]    cell_index,
	output logic      [1:0]    status,
	output logic      [1:0]    run_mode_out,
	output logic               still_running,
	output logic      [5:0]    state_out,
	output logic      [9:0]    head_out,
	output logic      [7:0]    symbol_read,
	output logic      [7:0]    cell_value,
	output logic      [10:0]   tape_used
);
	import tms_pkg::*;

	localparam int RW = $clog2(RULE_SLOTS);
	localparam int CW = $clog2(RULE_SLOTS + 1);
	localparam int HW = $clog2(TAPE_CELLS);
	localparam int LW = $clog2(TAPE_CELLS + 1);

	// tape position to physical address, base rotates on front growth
	function automatic logic [HW-1:0] phys(input logic [HW-1:0] b, input logic [HW-1:0] x);
		logic [HW:0] s;
		s = {1'b0, b} + {1'b0, x};
		if (s >= (HW+1)'(TAPE_CELLS)) begin
			s = s - (HW+1)'(TAPE_CELLS);
		end
		return s[HW-1:0];
	endfunction

	// latched request
	logic [2:0] act_q;
	logic [5:0] rst_q, rnx_q;
	logic [7:0] rrd_q, rwr_q, sym_in_q;
	logic [1:0] rmv_q;
	logic [9:0] ci_q;

	// machine state
	logic [5:0]    start_q, accept_q, reject_q, cur_q;
	logic [1:0]    mode_q;
	logic [CW-1:0] count_q;
	logic [LW-1:0] len_q;
	logic [HW-1:0] head_q, base_q;

	// per-rule match keys in flops
	logic [5:0] key_st_q [RULE_SLOTS];
	logic [7:0] key_rd_q [RULE_SLOTS];

	logic [RULE_SLOTS-1:0] m1_q, m2_q;
	logic [7:0] sym_q;
	logic       found_q;
	logic       gf_q;

	logic [1:0] res_status_q;
	logic       res_run_q;
	logic [7:0] res_sym_q, res_cell_q;

	// rams
	logic [7:0]    tape_rdata, tape_wdata;
	logic          tape_we;
	logic [HW-1:0] tape_waddr, tape_raddr;
	logic [15:0]   rule_rdata;
	logic [RW-1:0] sel_idx;
	logic          sel_found;

	tms_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape (
		.clk(clk), .we(tape_we), .waddr(tape_waddr), .wdata(tape_wdata),
		.re(cmd.tape_rd), .raddr(tape_raddr), .rdata(tape_rdata)
	);

	logic rule_we;
	assign rule_we = cmd.exec && act_q == ACT_ADD_RULE && count_q < CW'(RULE_SLOTS);

	tms_ram #(.WIDTH(16), .DEPTH(RULE_SLOTS)) u_rules (
		.clk(clk), .we(rule_we), .waddr(count_q[RW-1:0]),
		.wdata({rwr_q, rmv_q, rnx_q}),
		.re(cmd.sel), .raddr(sel_idx), .rdata(rule_rdata)
	);

	// rule fields as read back
	logic [7:0] r_wr;
	logic [1:0] r_mv;
	logic [5:0] r_nx;
	assign r_wr = rule_rdata[15:8];
	assign r_mv = rule_rdata[7:6];
	assign r_nx = rule_rdata[5:0];

	// step decisions
	logic head_in, left, right, gf, gb, full, halt, step_go;
	assign head_in = LW'(head_q) < len_q;
	assign left    = r_mv == MOVE_LEFT;
	assign right   = r_mv == MOVE_RIGHT;
	assign gf      = left && head_q == '0;
	assign gb      = right && len_q != '0 && LW'(head_q) == len_q - LW'(1);
	assign full    = (gf && len_q >= LW'(TAPE_CELLS)) ||
	                 (right && head_q >= HW'(TAPE_CELLS - 1));
	assign halt    = r_nx == accept_q || r_nx == reject_q;
	assign step_go = act_q == ACT_STEP && mode_q == MODE_NORMAL && found_q && !full;
	assign stat.grow_req = cmd.exec && step_go && (gf || gb);

	assign tape_raddr = (act_q == ACT_READ) ? phys(base_q, HW'(ci_q)) : phys(base_q, head_q);

	always_comb begin
		tape_we    = 1'b0;
		tape_waddr = phys(base_q, head_q);
		tape_wdata = r_wr;
		if (cmd.exec && act_q == ACT_APPEND && len_q < LW'(TAPE_CELLS)) begin
			tape_we    = 1'b1;
			tape_waddr = phys(base_q, len_q[HW-1:0]);
			tape_wdata = sym_in_q;
		end else if (cmd.exec && step_go && r_wr != SYM_ANY && head_in) begin
			tape_we = 1'b1;
		end else if (cmd.grow) begin
			tape_we    = 1'b1;
			tape_wdata = SYM_BLANK;
			tape_waddr = gf_q ? base_q : phys(base_q, len_q[HW-1:0] - HW'(1));
		end
	end

	// first match, then first star rule
	always_comb begin
		logic [RW-1:0] i1, i2;
		logic          f1, f2;
		i1 = '0; i2 = '0; f1 = 1'b0; f2 = 1'b0;
		for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
			if (m1_q[i]) begin i1 = RW'(i); f1 = 1'b1; end
			if (m2_q[i]) begin i2 = RW'(i); f2 = 1'b1; end
		end
		sel_idx   = f1 ? i1 : i2;
		sel_found = f1 || f2;
	end

	logic [7:0] sym_now;
	assign sym_now = head_in ? tape_rdata : SYM_BLANK;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q <= action; rst_q <= rule_state; rrd_q <= rule_read;
			rwr_q <= rule_write; rmv_q <= rule_move; rnx_q <= rule_next;
			sym_in_q <= tape_symbol; ci_q <= cell_index;
		end
		if (rule_we) begin
			key_st_q[count_q[RW-1:0]] <= rst_q;
			key_rd_q[count_q[RW-1:0]] <= rrd_q;
		end
		if (cmd.match) begin
			sym_q <= sym_now;
			for (int i = 0; i < RULE_SLOTS; i++) begin
				m1_q[i] <= CW'(i) < count_q && key_st_q[i] == cur_q &&
				           (sym_now == SYM_ANY || key_rd_q[i] == sym_now);
				m2_q[i] <= CW'(i) < count_q && key_st_q[i] == cur_q &&
				           key_rd_q[i] == SYM_ANY;
			end
		end
		if (cmd.sel) begin
			found_q <= sel_found;
		end
		if (cmd.exec) begin
			gf_q <= gf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 6'd0; accept_q <= 6'd1; reject_q <= 6'd2;
			cur_q <= '0; mode_q <= MODE_NORMAL; count_q <= '0;
			len_q <= '0; head_q <= '0; base_q <= '0;
			res_status_q <= ST_OK; res_run_q <= 1'b0;
			res_sym_q <= '0; res_cell_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_START:  start_q  <= cfg_data;
					CFG_ACCEPT: accept_q <= cfg_data;
					CFG_REJECT: reject_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.latch) begin
				res_status_q <= ST_OK; res_run_q <= 1'b0;
				res_sym_q <= '0; res_cell_q <= '0;
			end
			if (cmd.exec) begin
				case (act_q)
					ACT_CLEAR: begin
						count_q <= '0; len_q <= '0; head_q <= '0;
					end
					ACT_ADD_RULE: begin
						if (count_q >= CW'(RULE_SLOTS)) res_status_q <= ST_TABLE_FULL;
						else count_q <= count_q + CW'(1);
					end
					ACT_APPEND: begin
						if (len_q >= LW'(TAPE_CELLS)) res_status_q <= ST_TAPE_FULL;
						else len_q <= len_q + LW'(1);
					end
					ACT_START: begin
						cur_q <= start_q;
						if (start_q == accept_q) mode_q <= MODE_ACCEPT;
						else if (start_q == reject_q) mode_q <= MODE_REJECT;
						else mode_q <= MODE_NORMAL;
					end
					ACT_STEP: begin
						if (mode_q == MODE_NORMAL) begin
							res_sym_q <= sym_q;
							if (!found_q) begin
								mode_q <= MODE_ERROR;
								res_status_q <= ST_NO_RULE;
							end else if (full) begin
								res_status_q <= ST_TAPE_FULL;
							end else begin
								cur_q <= r_nx;
								if (gf || gb) len_q <= len_q + LW'(1);
								if (gf) begin
									base_q <= (base_q == '0) ? HW'(TAPE_CELLS - 1)
									                         : base_q - HW'(1);
								end
								if (r_nx == accept_q) mode_q <= MODE_ACCEPT;
								else if (r_nx == reject_q) mode_q <= MODE_REJECT;
								if (halt) begin
									if (gf) head_q <= head_q + HW'(1);
								end else begin
									res_run_q <= 1'b1;
									if (left && !gf) head_q <= head_q - HW'(1);
									else if (right) head_q <= head_q + HW'(1);
								end
							end
						end
					end
					ACT_READ: begin
						res_cell_q <= (32'(ci_q) < 32'(len_q)) ? tape_rdata : SYM_BLANK;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status        <= res_status_q;
			run_mode_out  <= mode_q;
			still_running <= res_run_q;
			state_out     <= cur_q;
			head_out      <= 10'(head_q);
			symbol_read   <= res_sym_q;
			cell_value    <= res_cell_q;
			tape_used     <= 11'(len_q);
		end
	end
endmodule
`default_nettype wire

// File: design/tms_checker.sv
// port-level checks for the turing machine stepper, bound to the top level
`default_nettype none
module tms_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] status,
	input wire logic [1:0] run_mode_out,
	input wire logic       still_running
);
	import tms_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while busy");

	a_running_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && still_running |-> status == ST_OK && run_mode_out == MODE_NORMAL)
		else $error("running result with bad status or mode");

	a_no_rule_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NO_RULE |-> run_mode_out == MODE_ERROR)
		else $error("missing rule without error mode");
endmodule

bind turing_machine_stepper tms_checker u_tms_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.run_mode_out(run_mode_out), .still_running(still_running)
);
`default_nettype wire

// File: verif/tms_checker.sv
// checker for the turing machine stepper: watches both channels, predicts and compares
`default_nettype none
module tms_scoreboard (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [5:0]  rule_state,
	input  wire logic [7:0]  rule_read,
	input  wire logic [7:0]  rule_write,
	input  wire logic [1:0]  rule_move,
	input  wire logic [5:0]  rule_next,
	input  wire logic [7:0]  tape_symbol,
	input  wire logic [9:0]  cell_index,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [1:0]  status,
	input  wire logic [1:0]  run_mode_out,
	input  wire logic        still_running,
	input  wire logic [5:0]  state_out,
	input  wire logic [9:0]  head_out,
	input  wire logic [7:0]  symbol_read,
	input  wire logic [7:0]  cell_value,
	input  wire logic [10:0] tape_used,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [5:0]  cfg_data,
	output int               fail_count,
	output int               pending
);
	import tms_pkg::*;

	localparam int SLOTS = 64;
	localparam int CELLS = 1024;

	typedef struct packed {
		logic [5:0] st;
		logic [7:0] rd;
		logic [7:0] wr;
		logic [1:0] mv;
		logic [5:0] nx;
	} rule_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  mode;
		logic        running;
		logic [5:0]  state;
		logic [9:0]  head;
		logic [7:0]  sym;
		logic [7:0]  cell_v;
		logic [10:0] used;
	} outcome_t;

	rule_t      rules[SLOTS];
	logic [7:0] tape[CELLS];
	int         n_rules, tape_len, head;
	logic [5:0] cur_state, start_st, accept_st, reject_st;
	logic [1:0] mode;
	outcome_t   awaited[$];

	assign pending = awaited.size();

	function automatic int find_rule(logic [5:0] st, logic [7:0] sym);
		for (int i = 0; i < n_rules; i++)
			if (rules[i].st == st && (sym == SYM_ANY || rules[i].rd == sym))
				return i;
		for (int i = 0; i < n_rules; i++)
			if (rules[i].st == st && rules[i].rd == SYM_ANY)
				return i;
		return -1;
	endfunction

	task automatic apply_request(output outcome_t o);
		int idx;
		logic [7:0] sym;
		rule_t r;
		logic lft, rgt, grow_front, grow_back;
		o = '0;
		case (action)
			ACT_CLEAR: begin
				n_rules = 0;
				tape_len = 0;
				head = 0;
			end
			ACT_ADD_RULE: begin
				if (n_rules >= SLOTS) o.status = ST_TABLE_FULL;
				else begin
					rules[n_rules] = '{rule_state, rule_read, rule_write, rule_move, rule_next};
					n_rules++;
				end
			end
			ACT_APPEND: begin
				if (tape_len >= CELLS) o.status = ST_TAPE_FULL;
				else begin
					tape[tape_len] = tape_symbol;
					tape_len++;
				end
			end
			ACT_START: begin
				cur_state = start_st;
				if (cur_state == accept_st) mode = MODE_ACCEPT;
				else if (cur_state == reject_st) mode = MODE_REJECT;
				else mode = MODE_NORMAL;
			end
			ACT_STEP: if (mode == MODE_NORMAL) begin
				sym = (head < tape_len) ? tape[head] : SYM_BLANK;
				idx = find_rule(cur_state, sym);
				o.sym = sym;
				if (idx < 0) begin
					mode = MODE_ERROR;
					o.status = ST_NO_RULE;
				end else begin
					r = rules[idx];
					lft = r.mv == MOVE_LEFT;
					rgt = r.mv == MOVE_RIGHT;
					grow_front = lft && head == 0;
					grow_back = rgt && tape_len > 0 && head == tape_len - 1;
					if ((grow_front && tape_len >= CELLS) || (rgt && head >= CELLS - 1))
						o.status = ST_TAPE_FULL;
					else begin
						if (r.wr != SYM_ANY && head < tape_len) tape[head] = r.wr;
						if (grow_front) begin
							for (int i = tape_len; i > 0; i--) tape[i] = tape[i - 1];
							tape[0] = SYM_BLANK;
							tape_len++;
							head++;
						end else if (grow_back) begin
							tape[tape_len] = SYM_BLANK;
							tape_len++;
						end
						cur_state = r.nx;
						if (cur_state == accept_st) mode = MODE_ACCEPT;
						else if (cur_state == reject_st) mode = MODE_REJECT;
						else begin
							if (lft) head--;
							else if (rgt) head++;
							o.running = 1'b1;
						end
					end
				end
			end
			ACT_READ: o.cell_v = (cell_index < tape_len) ? tape[cell_index] : SYM_BLANK;
			default: ;
		endcase
		o.mode = mode;
		o.state = cur_state;
		o.head = head[9:0];
		o.used = tape_len[10:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t o, e;
		if (!arst_n) begin
			n_rules = 0;
			tape_len = 0;
			head = 0;
			cur_state = '0;
			mode = MODE_NORMAL;
			start_st = 6'd0;
			accept_st = 6'd1;
			reject_st = 6'd2;
			fail_count = 0;
			awaited.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_START:  start_st = cfg_data;
					CFG_ACCEPT: accept_st = cfg_data;
					CFG_REJECT: reject_st = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					e = awaited.pop_front();
					o = '{status, run_mode_out, still_running, state_out, head_out,
						symbol_read, cell_value, tape_used};
					if (o != e) begin
						fail_count++;
						if (o.status != e.status)
							$error("status expected %0d got %0d", e.status, o.status);
						if (o.mode != e.mode)
							$error("run_mode_out expected %0d got %0d", e.mode, o.mode);
						if (o.running != e.running)
							$error("still_running expected %0d got %0d", e.running, o.running);
						if (o.state != e.state)
							$error("state_out expected %0d got %0d", e.state, o.state);
						if (o.head != e.head)
							$error("head_out expected %0d got %0d", e.head, o.head);
						if (o.sym != e.sym)
							$error("symbol_read expected %0d got %0d", e.sym, o.sym);
						if (o.cell_v != e.cell_v)
							$error("cell_value expected %0d got %0d", e.cell_v, o.cell_v);
						if (o.used != e.used)
							$error("tape_used expected %0d got %0d", e.used, o.used);
					end
				end
			end
			if (in_valid && !in_stall) begin
				apply_request(o);
				awaited = {awaited, o};
			end
		end
	end
endmodule
`default_nettype wire

// File: verif/tb_turing_machine_stepper.sv
// testbench top for the turing machine stepper: stimulus, reset and verdict
`default_nettype none
module tb_turing_machine_stepper;
	import tms_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	// action codes with no meaning and the move code that is not a move
	localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
	localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
	localparam logic [1:0] MOVE_ODD      = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  action = ACT_CLEAR;
	logic [5:0]  rule_state = '0;
	logic [7:0]  rule_read = '0;
	logic [7:0]  rule_write = '0;
	logic [1:0]  rule_move = '0;
	logic [5:0]  rule_next = '0;
	logic [7:0]  tape_symbol = '0;
	logic [9:0]  cell_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [1:0]  run_mode_out;
	logic        still_running;
	logic [5:0]  state_out;
	logic [9:0]  head_out;
	logic [7:0]  symbol_read;
	logic [7:0]  cell_value;
	logic [10:0] tape_used;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_START;
	logic [5:0]  cfg_data = '0;
	int          fail_count, pending;
	int          idle_cycles;
	int          rx_wait = 0;
	bit          drain_stall;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	turing_machine_stepper dut (.*);
	tms_scoreboard chk (.*);

	// receiver: draws a fresh random wait for every result taken
	always @(posedge clk) begin
		if (out_valid && !out_stall) rx_wait = $urandom_range(0, 5);
		else if (out_valid && rx_wait != 0) rx_wait--;
	end

	always @(negedge clk) begin
		out_stall <= !drain_stall && rx_wait != 0;
	end

	// watchdog: cycles with nothing accepted on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// hand one request over and hold it until accepted; valid drops only on a gap
	task automatic send(input logic [2:0] act, input logic [5:0] st, input logic [7:0] rd,
			input logic [7:0] wr, input logic [1:0] mv, input logic [5:0] nx,
			input logic [7:0] sym, input logic [9:0] idx);
		int wait_n;
		wait_n = $urandom_range(0, 5);
		if (wait_n != 0) begin
			in_valid <= 1'b0;
			repeat (wait_n) @(negedge clk);
		end
		action <= act;
		rule_state <= st;
		rule_read <= rd;
		rule_write <= wr;
		rule_move <= mv;
		rule_next <= nx;
		tape_symbol <= sym;
		cell_index <= idx;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic rule(input logic [5:0] st, input logic [7:0] rd, input logic [7:0] wr,
			input logic [1:0] mv, input logic [5:0] nx);
		send(ACT_ADD_RULE, st, rd, wr, mv, nx, '0, '0);
	endtask

	task automatic simple(input logic [2:0] act, input logic [7:0] sym, input logic [9:0] idx);
		send(act, 6'($urandom), 8'($urandom), 8'($urandom), 2'($urandom), 6'($urandom),
			sym, idx);
	endtask

	// stop sending and wait for every result before a register write
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// stop sending and take every result with no stall
	task automatic drain();
		in_valid <= 1'b0;
		drain_stall = 1'b1;
		while (pending != 0) @(negedge clk);
		drain_stall = 1'b0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// random symbol biased toward a small alphabet plus star and blank
	function automatic logic [7:0] pick_sym();
		case ($urandom_range(0, 9))
			0: return SYM_ANY;
			1: return SYM_BLANK;
			2: return 8'($urandom);
			default: return 8'($urandom_range(8'h30, 8'h33));
		endcase
	endfunction

	function automatic logic [5:0] pick_state(input logic [5:0] base);
		return ($urandom_range(0, 19) == 0) ? 6'($urandom) : base + 6'($urandom_range(0, 5));
	endfunction

	initial begin
		int sent;
		logic [5:0] base;
		int n;
		bit drained;
		drain_stall = 1'b0;
		drained = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset registers, empty tape, extremes
		simple(ACT_STEP, '0, '0);          // no rule matches: error
		simple(ACT_READ, '0, 10'h3FF);     // read beyond end gives blank
		simple(ACT_START, '0, '0);         // start equals reset state 0
		rule(6'd0, SYM_BLANK, 8'hFF, MOVE_LEFT, 6'd3);  // grow at the front
		rule(6'd3, SYM_ANY, SYM_ANY, MOVE_RIGHT, 6'd4); // star fallback, keep symbol
		rule(6'd4, 8'h00, 8'h00, MOVE_ODD, 6'd1);       // odd move code then accept
		rule(6'd4, SYM_BLANK, 8'hAA, MOVE_RIGHT, 6'd2); // reject
		simple(ACT_APPEND, 8'h00, '0);
		simple(ACT_APPEND, SYM_ANY, '0);   // star on tape matches any rule
		simple(ACT_STEP, '0, '0);
		simple(ACT_STEP, '0, '0);
		simple(ACT_STEP, '0, '0);
		simple(ACT_STEP, '0, '0);          // halted: no change
		simple(ACT_READ, '0, 10'd0);
		simple(ACT_READ, '0, 10'd1);
		simple(ACT_UNUSED_LO, '0, '0);
		simple(ACT_UNUSED_HI, '0, '0);
		simple(ACT_CLEAR, '0, '0);
		settle();

		// fill the table past full, then the tape past full
		rule(6'd0, SYM_ANY, SYM_ANY, MOVE_LEFT, 6'd5);
		for (int i = 0; i < 65; i++) rule(6'd63, 8'($urandom), 8'($urandom), MOVE_RIGHT, 6'd63);
		for (int i = 0; i < 1026; i++) send(ACT_APPEND, '0, '0, '0, '0, '0,
			8'($urandom), '0);
		settle();
		write_reg(CFG_START, 6'd0);
		write_reg(CFG_ACCEPT, 6'd63);
		write_reg(CFG_REJECT, 6'd63);
		simple(ACT_START, '0, '0);
		simple(ACT_STEP, '0, '0);          // left move off a full tape
		simple(ACT_READ, '0, 10'd1023);
		settle();
		write_reg(CFG_START, 6'd63);
		simple(ACT_START, '0, '0);         // accept wins over reject when equal
		simple(ACT_STEP, '0, '0);          // halted: no change
		simple(ACT_CLEAR, '0, '0);
		settle();

		// random programs: small tables over a few states, then runs of steps
		sent = 0;
		while (sent < 300) begin
			if ($urandom_range(0, 3) == 0) begin
				settle();
				base = 6'($urandom);
				write_reg(CFG_START, ($urandom_range(0, 7) == 0) ? 6'h3F : base);
				write_reg(CFG_ACCEPT, ($urandom_range(0, 7) == 0) ? 6'h00 : base + 6'd5);
				write_reg(CFG_REJECT, ($urandom_range(0, 7) == 0) ? 6'h3F : base + 6'd6);
			end else base = 6'($urandom_range(0, 3));
			simple(ACT_CLEAR, '0, '0);
			n = $urandom_range(2, 14);
			for (int i = 0; i < n; i++)
				rule(pick_state(base), pick_sym(), pick_sym(), 2'($urandom), pick_state(base));
			sent += n + 1;
			n = $urandom_range(0, 8);
			for (int i = 0; i < n; i++) simple(ACT_APPEND, pick_sym(), '0);
			sent += n;
			simple(ACT_START, '0, '0);
			n = $urandom_range(4, 20);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 6) == 0) simple(ACT_READ, '0, 10'($urandom_range(0, 12)));
				else if ($urandom_range(0, 30) == 0) simple(3'($urandom), pick_sym(),
					10'($urandom));
				else simple(ACT_STEP, '0, '0);
			end
			sent += n + 1;
			// hold the sender once until all results are back
			if (!drained && sent >= 150) begin
				drained = 1'b1;
				drain();
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (fail_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
design/tms_pkg.sv
design/tms_ram.sv
design/tms_ctrl.sv
design/tms_dp.sv
design/turing_machine_stepper.sv
design/tms_checker.sv
verif/tms_checker.sv
verif/tb_turing_machine_stepper.sv
